[design/mrrb_pkg.sv]
// ----------------------------------------------------------------------------
// mrrb_pkg
// shared types and codes of the multipart round-robin balancer
// ----------------------------------------------------------------------------
package mrrb_pkg;

    localparam logic [2:0] REQ_ATTACH    = 3'd0;
    localparam logic [2:0] REQ_TERMINATE = 3'd1;
    localparam logic [2:0] REQ_ACTIVATE  = 3'd2;
    localparam logic [2:0] REQ_ADMIT     = 3'd3;
    localparam logic [2:0] REQ_SEND      = 3'd4;
    localparam logic [2:0] REQ_QUERY     = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_AGAIN    = 3'd1;
    localparam logic [2:0] ST_REFUSED  = 3'd2;
    localparam logic [2:0] ST_ROLLBACK = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
    } t_sts;

endpackage

[design/mrrb_ctrl.sv]
// ----------------------------------------------------------------------------
// mrrb_ctrl
// handshake and sequencing controller
// ----------------------------------------------------------------------------
module mrrb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output mrrb_pkg::t_cmd  o_cmd,
    input  mrrb_pkg::t_sts  i_sts
);
    import mrrb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

[design/mrrb_dp.sv]
// ----------------------------------------------------------------------------
// mrrb_dp
// port table, counters and one walk step per cycle
// ----------------------------------------------------------------------------
module mrrb_dp #(
    parameter int MAX_PORTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mrrb_pkg::t_cmd  i_cmd,
    output mrrb_pkg::t_sts  o_sts,
    input  logic [2:0]      i_req_type,
    input  logic [2:0]      i_port_id,
    input  logic            i_admit_value,
    input  logic            i_frame_more,
    input  logic [7:0]      i_ready_mask,
    output logic [2:0]      o_status,
    output logic [2:0]      o_target_port,
    output logic            o_target_valid,
    output logic            o_rollback_port,
    output logic            o_can_send
);
    import mrrb_pkg::*;

    localparam int IW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int CW = $clog2(MAX_PORTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_PORTS);

    logic [2:0]    r_order [MAX_PORTS];
    logic [CW-1:0] r_att, r_act;
    logic [IW-1:0] r_cur;
    logic          r_inmsg, r_drop;
    logic [7:0]    r_adm, r_attb;

    logic [2:0] r_req, r_port;
    logic       r_admv, r_more;
    logic [7:0] r_mask;
    logic       r_walk;
    logic [2:0] r_status, r_tgt;
    logic       r_tv, r_rb, r_can;

    // slot lookup
    logic [IW-1:0] w_slot;
    always_comb begin
        w_slot = '0;
        for (int i = MAX_PORTS - 1; i >= 0; i--)
            if (CW'(i) < r_att && r_order[i] == r_port) w_slot = IW'(i);
    end

    logic [2:0] w_cport;
    logic       w_crdy;
    assign w_cport = r_order[r_cur];
    assign w_crdy  = r_mask[w_cport];

    logic [7:0]    w_bit;
    logic          w_portok, w_atch;
    logic [CW-1:0] w_slotc, w_curc, w_actm1;
    assign w_bit    = 8'(1) << r_port;
    assign w_portok = {29'd0, r_port} < 32'(MAX_PORTS);
    assign w_atch   = (r_attb & w_bit) != 8'd0;
    assign w_slotc  = CW'(w_slot);
    assign w_curc   = CW'(r_cur);
    assign w_actm1  = r_act - CW'(1);

    assign o_sts.walk_done = !r_walk;

    function automatic logic [IW-1:0] ix(input logic [CW-1:0] v);
        return v[IW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_port <= i_port_id;
            r_admv <= i_admit_value;
            r_more <= i_frame_more;
            r_mask <= i_ready_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att <= '0; r_act <= '0; r_cur <= '0;
            r_inmsg <= 1'b0; r_drop <= 1'b0;
            r_adm <= '0; r_attb <= '0; r_walk <= 1'b0;
        end else if (i_cmd.load) begin
            r_walk <= 1'b1;
        end else if (i_cmd.step && r_walk) begin
            r_walk <= 1'b0;
            r_status <= ST_OK; r_tgt <= '0; r_tv <= 1'b0; r_rb <= 1'b0; r_can <= 1'b0;
            if (r_req > REQ_QUERY || (r_req <= REQ_ADMIT && !w_portok)) begin
                r_status <= ST_INVALID;
            end else if (r_req == REQ_ATTACH) begin
                if (w_atch || r_att >= MAXC) r_status <= ST_INVALID;
                else begin
                    r_order[ix(r_att)] <= r_order[ix(r_act)];
                    r_order[ix(r_act)] <= r_port;
                    r_att  <= r_att + CW'(1);
                    r_act  <= r_act + CW'(1);
                    r_attb <= r_attb | w_bit;
                    r_adm  <= r_adm | w_bit;
                end
            end else if (r_req <= REQ_ADMIT && !w_atch) begin
                r_status <= ST_INVALID;
            end else if (r_req == REQ_TERMINATE) begin
                if (w_slot == r_cur && r_inmsg) r_drop <= 1'b1;
                r_attb <= r_attb & ~w_bit;
                r_adm  <= r_adm & ~w_bit;
                r_att  <= r_att - CW'(1);
                if (w_slotc < r_act) begin
                    // move last active into the slot, then last attached into the last active place
                    r_act <= w_actm1;
                    if (w_curc == w_actm1) r_cur <= '0;
                    r_order[w_slot]     <= r_order[ix(w_actm1)];
                    r_order[ix(w_actm1)] <= r_order[ix(r_att - CW'(1))];
                end else begin
                    r_order[w_slot] <= r_order[ix(r_att - CW'(1))];
                end
            end else if (r_req == REQ_ACTIVATE || r_req == REQ_ADMIT) begin
                if (r_req == REQ_ACTIVATE || r_admv) begin
                    if (r_req == REQ_ADMIT) r_adm <= r_adm | w_bit;
                    if ((r_req == REQ_ACTIVATE ? (r_adm & w_bit) != 8'd0
                                               : ((r_adm & w_bit) == 8'd0
                                                  && r_mask[r_port]))
                        && w_slotc >= r_act) begin
                        r_order[w_slot]     <= r_order[ix(r_act)];
                        r_order[ix(r_act)] <= r_order[w_slot];
                        r_act <= r_act + CW'(1);
                    end
                end else if ((r_adm & w_bit) != 8'd0) begin
                    r_adm <= r_adm & ~w_bit;
                    if (w_slot == r_cur && r_inmsg) r_drop <= 1'b1;
                    if (w_slotc < r_act) begin
                        r_act <= w_actm1;
                        r_order[w_slot]     <= r_order[ix(w_actm1)];
                        r_order[ix(w_actm1)] <= r_order[w_slot];
                        if (w_curc == w_actm1) r_cur <= '0;
                        else if (w_curc > w_slotc) r_cur <= r_cur - IW'(1);
                    end
                end
            end else if (w_curc >= r_act && r_act != '0) begin
                r_cur  <= '0;
                r_walk <= 1'b1;
            end else if (r_req == REQ_SEND && r_drop) begin
                r_inmsg <= r_more; r_drop <= r_more;
            end else if (r_act == CW'(1) && r_cur == '0 && !(r_req == REQ_QUERY && r_inmsg)) begin
                if (!w_crdy) begin
                    r_act <= '0;
                    if (r_req == REQ_SEND) r_status <= ST_AGAIN;
                end else if (r_req == REQ_SEND) begin
                    r_tgt <= w_cport; r_tv <= 1'b1; r_inmsg <= r_more;
                end else r_can <= 1'b1;
            end else if (r_req == REQ_QUERY) begin
                if (r_inmsg) r_can <= 1'b1;
                else if (r_act == '0) begin
                    r_cur <= '0;
                end else if (w_crdy) r_can <= 1'b1;
                else begin
                    r_act <= w_actm1;
                    r_order[r_cur]       <= r_order[ix(w_actm1)];
                    r_order[ix(w_actm1)] <= r_order[r_cur];
                    if (w_curc == w_actm1) r_cur <= '0;
                    r_walk <= 1'b1;
                end
            end else begin
                if (r_act == '0) begin
                    r_cur <= '0;
                    r_status <= (r_adm != 8'd0) ? ST_AGAIN : ST_REFUSED;
                end else if (w_crdy) begin
                    r_tgt <= w_cport; r_tv <= 1'b1; r_inmsg <= r_more;
                    if (!r_more)
                        r_cur <= (w_curc + CW'(1) >= r_act) ? '0 : r_cur + IW'(1);
                end else if (r_inmsg) begin
                    r_tgt <= w_cport; r_rb <= 1'b1; r_drop <= r_more;
                    r_inmsg <= 1'b0; r_status <= ST_ROLLBACK;
                end else begin
                    r_act <= w_actm1;
                    if (w_curc < w_actm1) begin
                        r_order[r_cur]       <= r_order[ix(w_actm1)];
                        r_order[ix(w_actm1)] <= r_order[r_cur];
                    end else r_cur <= '0;
                    r_walk <= 1'b1;
                end
            end
        end
    end

    assign o_status        = r_status;
    assign o_target_port   = r_tgt;
    assign o_target_valid  = r_tv;
    assign o_rollback_port = r_rb;
    assign o_can_send      = r_can;

endmodule

[design/multipart_round_robin_balancer_core.sv]
// ----------------------------------------------------------------------------
// multipart_round_robin_balancer_core
// round-robin port balancer with multipart message affinity
//
//   channel  direction  handshake            payload
//   request  in         i_valid / o_ready    i_req_type .. i_ready_mask
//   result   out        o_valid / i_ready    o_status .. o_can_send
//
// after accept the walk runs, and the result is then held valid until taken;
// the walk steps one table slot per cycle and takes a further step per
// unready port skipped (at most MAX_PORTS - 1)
// reset is synchronous: the table is empty, no port attached
// a stalled result holds the block, no request is taken until it leaves
// ----------------------------------------------------------------------------
module multipart_round_robin_balancer_core #(
    parameter int MAX_PORTS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [2:0] i_port_id,
    input  logic       i_admit_value,
    input  logic       i_frame_more,
    input  logic [7:0] i_ready_mask,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_status,
    output logic [2:0] o_target_port,
    output logic       o_target_valid,
    output logic       o_rollback_port,
    output logic       o_can_send
);
    import mrrb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    mrrb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    mrrb_dp #(.MAX_PORTS(MAX_PORTS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_req_type, .i_port_id, .i_admit_value, .i_frame_more, .i_ready_mask,
        .o_status, .o_target_port, .o_target_valid, .o_rollback_port, .o_can_send
    );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the multipart round-robin balancer core
//
// drives attach, terminate, activate, admission, send and query requests with
// random ready masks, models the port table in step, and compares every
// result field with the predicted one, under several idling phases
// ----------------------------------------------------------------------------
module tb_top;
    import mrrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPORT = 8;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] target;
        logic       tvalid;
        logic       rollback;
        logic       can;
    } t_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [2:0] i_req_type;
    logic [2:0] i_port_id;
    logic       i_admit_value;
    logic       i_frame_more;
    logic [7:0] i_ready_mask;
    logic       o_valid;
    logic       i_ready;
    logic [2:0] o_status;
    logic [2:0] o_target_port;
    logic       o_target_valid;
    logic       o_rollback_port;
    logic       o_can_send;

    multipart_round_robin_balancer_core #(.MAX_PORTS(NPORT)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_port_id(i_port_id),
        .i_admit_value(i_admit_value), .i_frame_more(i_frame_more),
        .i_ready_mask(i_ready_mask), .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_target_port(o_target_port),
        .o_target_valid(o_target_valid), .o_rollback_port(o_rollback_port),
        .o_can_send(o_can_send)
    );

    // balancer state mirror
    logic [2:0] m_order [NPORT];
    int         m_attached;
    int         m_active;
    int         m_cursor;
    logic       m_in_msg;
    logic       m_dropping;
    logic [7:0] m_admitted;
    logic [7:0] m_attached_bits;

    t_result    expected_results [$];
    int         n_errors;
    int         n_results;
    int         n_sent;
    int         send_idle_pct;
    int         recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("timeout");
        $display("** multipart_round_robin_balancer_core: FAILED **");
        $finish;
    end

    function automatic int slot_of(logic [2:0] p);
        for (int i = 0; i < m_attached; i++)
            if (m_order[i] == p) return i;
        return 0;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [2:0] t;
        t = m_order[a];
        m_order[a] = m_order[b];
        m_order[b] = t;
    endfunction

    function automatic logic slot_ready(int s, logic [7:0] mask);
        return mask[m_order[s]];
    endfunction

    function automatic void drop_active(int idx, bit shift_cursor);
        m_active--;
        swap_slots(idx, m_active);
        if (m_cursor == m_active) m_cursor = 0;
        else if (shift_cursor && m_cursor > idx && m_cursor <= m_active) m_cursor--;
    endfunction

    function automatic t_result predict_balance(logic [2:0] req, logic [2:0] port,
                                                logic admit, logic more,
                                                logic [7:0] mask);
        t_result r;
        logic [7:0] bitv;
        logic att;
        int idx;
        int last;
        bit done;
        r = '0;
        bitv = 8'd1 << port;
        att = (m_attached_bits & bitv) != 0;
        if (req > REQ_QUERY) begin
            r.status = ST_INVALID;
        end else if (req == REQ_ATTACH) begin
            if (att || m_attached >= NPORT) begin
                r.status = ST_INVALID;
            end else begin
                m_order[m_attached] = port;
                m_attached++;
                m_attached_bits |= bitv;
                m_admitted |= bitv;
                swap_slots(m_attached - 1, m_active);
                m_active++;
            end
        end else if (req <= REQ_ADMIT && !att) begin
            r.status = ST_INVALID;
        end else if (req == REQ_TERMINATE) begin
            idx = slot_of(port);
            if (idx == m_cursor && m_in_msg) m_dropping = 1'b1;
            if (idx < m_active) drop_active(idx, 0);
            idx = slot_of(port);
            last = m_attached - 1;
            m_order[idx] = m_order[last];
            m_attached = last;
            m_attached_bits &= ~bitv;
            m_admitted &= ~bitv;
        end else if (req == REQ_ACTIVATE) begin
            idx = slot_of(port);
            if ((m_admitted & bitv) != 0 && idx >= m_active) begin
                swap_slots(idx, m_active);
                m_active++;
            end
        end else if (req == REQ_ADMIT) begin
            if (m_admitted[port] != admit) begin
                idx = slot_of(port);
                if (admit) begin
                    m_admitted |= bitv;
                    if (idx >= m_active && mask[port]) begin
                        swap_slots(idx, m_active);
                        m_active++;
                    end
                end else begin
                    m_admitted &= ~bitv;
                    if (idx == m_cursor && m_in_msg) m_dropping = 1'b1;
                    if (idx < m_active) drop_active(idx, 1);
                end
            end
        end else begin
            if (m_cursor >= m_active) m_cursor = 0;
            if (req == REQ_SEND) begin
                if (m_dropping) begin
                    m_in_msg = more;
                    m_dropping = more;
                end else if (m_active == 1 && m_cursor == 0) begin
                    if (!slot_ready(0, mask)) begin
                        m_active = 0;
                        r.status = ST_AGAIN;
                    end else begin
                        r.target = m_order[0];
                        r.tvalid = 1'b1;
                        m_in_msg = more;
                    end
                end else begin
                    done = 0;
                    while (m_active > 0 && !done) begin
                        if (slot_ready(m_cursor, mask)) begin
                            r.target = m_order[m_cursor];
                            r.tvalid = 1'b1;
                            break;
                        end
                        if (m_in_msg) begin
                            r.target = m_order[m_cursor];
                            r.rollback = 1'b1;
                            m_dropping = more;
                            m_in_msg = 1'b0;
                            r.status = ST_ROLLBACK;
                            done = 1;
                            break;
                        end
                        m_active--;
                        if (m_cursor < m_active) swap_slots(m_cursor, m_active);
                        else m_cursor = 0;
                    end
                    if (!done) begin
                        if (m_active == 0) begin
                            r.status = (m_admitted != 0) ? ST_AGAIN : ST_REFUSED;
                        end else begin
                            m_in_msg = more;
                            if (!more) begin
                                m_cursor++;
                                if (m_cursor >= m_active) m_cursor = 0;
                            end
                        end
                    end
                end
            end else begin
                if (m_in_msg) begin
                    r.can = 1'b1;
                end else if (m_active == 1 && m_cursor == 0) begin
                    if (slot_ready(0, mask)) r.can = 1'b1;
                    else m_active = 0;
                end else begin
                    while (m_active > 0) begin
                        if (slot_ready(m_cursor, mask)) begin
                            r.can = 1'b1;
                            break;
                        end
                        m_active--;
                        swap_slots(m_cursor, m_active);
                        if (m_cursor == m_active) m_cursor = 0;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 n_results, what, got, want);
        n_errors++;
    endtask

    task automatic send_request(logic [2:0] req, logic [2:0] port, logic admit,
                                logic more, logic [7:0] mask);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_port_id     <= port;
        i_admit_value <= admit;
        i_frame_more  <= more;
        i_ready_mask  <= mask;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.insert(expected_results.size(),
                                predict_balance(req, port, admit, more, mask));
        n_sent++;
    endtask

    // result side: stall control and checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                t_result w;
                if (expected_results.size() == 0) begin
                    report_mismatch("result without a pending transaction", 1, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                    if (o_target_port !== w.target)
                        report_mismatch("target_port", o_target_port, w.target);
                    if (o_target_valid !== w.tvalid)
                        report_mismatch("target_valid", o_target_valid, w.tvalid);
                    if (o_rollback_port !== w.rollback)
                        report_mismatch("rollback_port", o_rollback_port, w.rollback);
                    if (o_can_send !== w.can) report_mismatch("can_send", o_can_send, w.can);
                end
                n_results++;
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end else begin
            i_ready <= 1'b0;
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_mask();
        case ($urandom_range(3))
            0: return 8'hFF;
            1: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_request(REQ_SEND, 0, 0, 0, 8'hFF);
        send_request(REQ_QUERY, 0, 0, 0, 8'hFF);
        send_request(REQ_TERMINATE, 3, 0, 0, 8'hFF);
        send_request(3'd6, 7, 1, 1, 8'hFF);
        send_request(3'd7, 0, 0, 0, 8'h00);
        for (int p = 0; p < NPORT; p++) send_request(REQ_ATTACH, 3'(p), 0, 0, 8'hFF);
        send_request(REQ_ATTACH, 2, 0, 0, 8'hFF);
        send_request(REQ_SEND, 0, 0, 1, 8'hFF);
        send_request(REQ_SEND, 0, 0, 1, 8'h00);
        send_request(REQ_SEND, 0, 0, 0, 8'hFF);
        send_request(REQ_ADMIT, 7, 0, 0, 8'hFF);
        send_request(REQ_ADMIT, 7, 0, 0, 8'hFF);
        send_request(REQ_ACTIVATE, 7, 0, 0, 8'hFF);
        send_request(REQ_ADMIT, 7, 1, 0, 8'h7F);
        send_request(REQ_ACTIVATE, 7, 0, 0, 8'hFF);
        send_request(REQ_QUERY, 0, 0, 0, 8'h00);
        send_request(REQ_SEND, 0, 0, 0, 8'h00);
        send_request(REQ_TERMINATE, 0, 0, 0, 8'hFF);
        send_request(REQ_SEND, 0, 0, 0, 8'h01);
        wait_drained();
    endtask

    task automatic test_random(int n);
        logic [2:0] req;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 45) req = REQ_SEND;
            else if (k < 55) req = REQ_QUERY;
            else if (k < 68) req = REQ_ATTACH;
            else if (k < 78) req = REQ_TERMINATE;
            else if (k < 88) req = REQ_ACTIVATE;
            else if (k < 97) req = REQ_ADMIT;
            else req = 3'($urandom_range(7));
            send_request(req, 3'($urandom), 1'($urandom), ($urandom_range(2) != 0),
                         rand_mask());
        end
    endtask

    task automatic test_phase(int s_idle, int r_stall, int n);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        test_random(n);
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NPORT; i++) m_order[i] = '0;
        m_attached = 0; m_active = 0; m_cursor = 0;
        m_in_msg = 0; m_dropping = 0; m_admitted = '0; m_attached_bits = '0;
        n_errors = 0; n_results = 0; n_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_req_type = '0; i_port_id = '0; i_admit_value = 1'b0;
        i_frame_more = 1'b0; i_ready_mask = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_phase(0, 0, 340);
        test_phase(74, 0, 330);
        test_phase(0, 74, 330);
        test_phase(34, 34, 330);
        $display("%0d transactions sent, %0d results checked over four idling phases",
                 n_sent, n_results);
        if (n_errors == 0) $display("** multipart_round_robin_balancer_core: PASSED **");
        else $display("** multipart_round_robin_balancer_core: FAILED **");
        $finish;
    end
endmodule
